/* src/rfd_pkg.sv */
// Package for the stream frame deframer: payload structs, result kinds, constants
// and the job states of the back end (executor).
// Used by every module of the block; no dependencies.
`default_nettype none
package rfd_pkg;

   localparam int STORE_DEPTH_DEF = 4096;
   localparam int MAX_PENDING_DEF = 4;
   localparam int HDR_FIXED       = 24;
   localparam int HDR_EXTRA       = 2;
   localparam int HDR_RID_OFF     = 5;

   localparam logic [1:0] KIND_TAKEN = 2'd0;
   localparam logic [1:0] KIND_FRAME = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_LOST  = 2'd3;

   localparam logic       CMD_PUSH = 1'b0;
   localparam logic       CMD_READ = 1'b1;

   localparam logic [0:0] CSR_START = 1'd0;
   localparam logic [0:0] CSR_END   = 1'd1;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic [11:0] read_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        frame_ok;
      logic [11:0] frame_base;
      logic [12:0] frame_len;
      logic [12:0] req_id_len;
      logic [12:0] method_name_len;
      logic [31:0] err_code;
      logic [12:0] err_info_len;
      logic [12:0] data_len;
      logic [7:0]  read_byte;
   } rsp_type;

   // Back-end job states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDREQ,
      ST_RDWAIT,
      ST_WALK,
      ST_CALC,
      ST_OUT
   } bk_state_type;

endpackage
`default_nettype wire

/* src/rfd_front.sv */
// Front end: writes stream bytes to the store, tracks pending frame candidates and classifies
// each request into a job for the back end. Uses rfd_pkg.
`default_nettype none
module rfd_front #(
   parameter int STORE_DEPTH = rfd_pkg::STORE_DEPTH_DEF,
   parameter int MAX_PENDING = rfd_pkg::MAX_PENDING_DEF,
   parameter int AW          = $clog2(STORE_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         start_marker,
   input  wire logic [7:0]         end_marker,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire rfd_pkg::req_type   in_req,
   // job out
   output logic                    job_valid,
   input  wire logic               job_ready,
   output logic                    job_frame,
   output logic                    job_read,
   output logic                    job_lost,
   output logic [AW-1:0]           job_base,
   output logic [AW:0]             job_len,
   output logic [11:0]             job_offset,
   // store write port seen by the back end
   output logic                    st_we,
   output logic [AW-1:0]           st_waddr,
   output logic [7:0]              st_wdata
);
   import rfd_pkg::*;

   localparam int PW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
   localparam logic [AW:0] DEPTH_W = (AW+1)'(STORE_DEPTH);

   logic [AW-1:0] wpos_ff, wpos_in, cpos_ff, cpos_in;
   logic [AW:0]   ucnt_ff, ucnt_in;
   logic [MAX_PENDING-1:0] cv_ff, cv_in;
   logic [AW-1:0] cs_ff [MAX_PENDING];
   logic [AW-1:0] cs_in [MAX_PENDING];
   logic [31:0]   cl_ff [MAX_PENDING];
   logic [31:0]   cl_in [MAX_PENDING];
   logic [2:0]    cn_ff [MAX_PENDING];
   logic [2:0]    cn_in [MAX_PENDING];
   logic [AW:0]   lfl_ff, lfl_in;
   logic [AW-1:0] lfb_ff, lfb_in;

   logic          job_valid_ff, job_frame_ff, job_read_ff, job_lost_ff;
   logic [AW-1:0] job_base_ff;
   logic [AW:0]   job_len_ff;
   logic [11:0]   job_off_ff;

   logic          acc, push, lost, win, has_free;
   logic [PW-1:0] win_idx, free_idx;
   logic [AW-1:0] best_dist, start_age;
   logic [AW-1:0] off;

   // One-entry job queue: accept when empty or draining
   assign in_ready = !job_valid_ff || job_ready;
   assign acc      = in_valid && in_ready;
   assign push     = acc && (in_req.cmd == CMD_PUSH);

   assign st_we    = push;
   assign st_waddr = wpos_ff;
   assign st_wdata = in_req.data_byte;

   // Candidate update, winner pick and slot allocation
   always_comb begin
      wpos_in = wpos_ff; cpos_in = cpos_ff; ucnt_in = ucnt_ff; cv_in = cv_ff;
      cs_in = cs_ff; cl_in = cl_ff; cn_in = cn_ff; lfl_in = lfl_ff; lfb_in = lfb_ff;
      lost = 1'b0; win = 1'b0; win_idx = '0; best_dist = '0;
      has_free = 1'b0; free_idx = '0; start_age = '0; off = '0;
      if (push) begin
         if (ucnt_ff >= DEPTH_W) begin
            lost    = 1'b1;
            cpos_in = cpos_ff + 1'b1;
            ucnt_in = DEPTH_W - 1'b1;
            for (int i = 0; i < MAX_PENDING; i++)
               if (cv_ff[i] && cs_ff[i] == wpos_ff) cv_in[i] = 1'b0;
         end
         ucnt_in = ucnt_in + 1'b1;
         for (int i = 0; i < MAX_PENDING; i++) begin
            off       = wpos_ff - cs_ff[i];
            start_age = cs_ff[i] - cpos_in;
            if (cv_in[i]) begin
               if (cn_ff[i] < 3'd4) begin
                  cl_in[i] = {cl_ff[i][23:0], in_req.data_byte};
                  cn_in[i] = cn_ff[i] + 3'd1;
                  if (cn_ff[i] == 3'd3 &&
                      ({cl_ff[i][23:0], in_req.data_byte} < 32'd6 ||
                       {cl_ff[i][23:0], in_req.data_byte} > 32'(STORE_DEPTH)))
                     cv_in[i] = 1'b0;
               end else if ({1'b0, off} + 1'b1 == cl_ff[i][AW:0] &&
                            cl_ff[i][31:AW+1] == '0) begin
                  if (in_req.data_byte == end_marker) begin
                     if (!win || start_age < best_dist) begin
                        win = 1'b1; win_idx = PW'(i); best_dist = start_age;
                     end
                  end else begin
                     cv_in[i] = 1'b0;
                  end
               end
            end
         end
         wpos_in = wpos_ff + 1'b1;
         if (win) begin
            lfb_in  = cs_ff[win_idx];
            lfl_in  = cl_ff[win_idx][AW:0];
            cv_in   = '0;
            cpos_in = wpos_in;
            ucnt_in = '0;
         end else if (in_req.data_byte == start_marker) begin
            for (int i = MAX_PENDING-1; i >= 0; i--)
               if (!cv_in[i]) begin has_free = 1'b1; free_idx = PW'(i); end
            if (has_free) begin
               cv_in[free_idx] = 1'b1;
               cs_in[free_idx] = wpos_ff;
               cl_in[free_idx] = '0;
               cn_in[free_idx] = '0;
            end
         end
      end
   end

   // Hold state and the job register
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0; cpos_ff <= '0; ucnt_ff <= '0; cv_ff <= '0;
         lfl_ff <= '0; lfb_ff <= '0; job_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PENDING; i++) begin
            cs_ff[i] <= '0; cl_ff[i] <= '0; cn_ff[i] <= '0;
         end
      end else begin
         wpos_ff <= wpos_in; cpos_ff <= cpos_in; ucnt_ff <= ucnt_in; cv_ff <= cv_in;
         cs_ff <= cs_in; cl_ff <= cl_in; cn_ff <= cn_in;
         lfl_ff <= lfl_in; lfb_ff <= lfb_in;
         if (acc) job_valid_ff <= 1'b1;
         else if (job_ready) job_valid_ff <= 1'b0;
      end
      if (acc) begin
         job_read_ff  <= (in_req.cmd == CMD_READ);
         job_frame_ff <= win;
         job_lost_ff  <= lost;
         job_base_ff  <= win ? cs_ff[win_idx] : lfb_ff;
         job_len_ff   <= win ? cl_ff[win_idx][AW:0] : lfl_ff;
         job_off_ff   <= in_req.read_offset;
      end
   end

   assign job_valid  = job_valid_ff;
   assign job_frame  = job_frame_ff;
   assign job_read   = job_read_ff;
   assign job_lost   = job_lost_ff;
   assign job_base   = job_base_ff;
   assign job_len    = job_len_ff;
   assign job_offset = job_off_ff;
endmodule
`default_nettype wire

/* src/rfd_back.sv */
// Back end: holds the byte store, walks frame headers byte by byte, one job at a
// time, and answers read-back requests, with a registered result. Uses rfd_pkg.
`default_nettype none
module rfd_back #(
   parameter int STORE_DEPTH = rfd_pkg::STORE_DEPTH_DEF,
   parameter int AW          = $clog2(STORE_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               st_we,
   input  wire logic [AW-1:0]      st_waddr,
   input  wire logic [7:0]         st_wdata,
   input  wire logic               job_valid,
   output logic                    job_ready,
   input  wire logic               job_frame,
   input  wire logic               job_read,
   input  wire logic               job_lost,
   input  wire logic [AW-1:0]      job_base,
   input  wire logic [AW:0]        job_len,
   input  wire logic [11:0]        job_offset,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rfd_pkg::rsp_type        rsp
);
   import rfd_pkg::*;

   localparam logic [AW:0] DEPTH_W = (AW+1)'(STORE_DEPTH);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rdata_ff;

   bk_state_type st_ff, st_in;
   logic [AW+2:0] k_ff, k_in;      // header byte offset
   logic [1:0]    fld_ff, fld_in;  // field index
   logic [1:0]    bc_ff, bc_in;    // byte count in word
   logic [31:0]   w_ff, w_in;
   logic          ok_ff, ok_in, big_ff, big_in;
   logic [31:0]   rid_ff, rid_in, mnl_ff, mnl_in, ec_ff, ec_in, eil_ff, eil_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in, rsp_out_ff;
   logic          load_rsp;
   logic [AW-1:0] raddr;
   logic          past;
   logic [31:0]   wnext;
   logic [35:0]   dl;

   // Store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (st_we) mem[st_waddr] <= st_wdata;
      rdata_ff <= mem[raddr];
   end

   assign past  = big_ff || (k_ff >= {2'b0, job_len});
   assign raddr = job_read ? (job_base + AW'(job_offset)) : (job_base + k_ff[AW-1:0]);
   assign wnext = {w_ff[23:0], past ? 8'd0 : rdata_ff};
   assign dl    = {4'b0, 19'b0, job_len} - {4'b0, rid_ff} - {4'b0, mnl_ff}
                  - {4'b0, eil_ff} - 36'(HDR_FIXED + HDR_EXTRA);

   function automatic logic [12:0] sat(input logic [35:0] v);
      logic [12:0] r;
      r = (v > 36'(STORE_DEPTH)) ? 13'(STORE_DEPTH) : 13'(v);
      return r;
   endfunction

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:   if (job_valid) begin
                       if (job_frame) st_in = ST_RDWAIT;
                       else if (job_read) st_in = ST_RDREQ;
                       else st_in = ST_OUT;
                    end
         ST_RDREQ:  st_in = ST_OUT;
         ST_RDWAIT: st_in = ST_WALK;
         ST_WALK:   if (fld_ff == 2'd3 && bc_ff == 2'd3) st_in = ST_CALC;
                    else st_in = ST_RDWAIT;
         ST_CALC:   st_in = ST_OUT;
         ST_OUT:    if (!rsp_valid_ff || rsp_ready) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   // Walk datapath and result build
   always_comb begin
      k_in = k_ff; fld_in = fld_ff; bc_in = bc_ff; w_in = w_ff; ok_in = ok_ff;
      big_in = big_ff; rid_in = rid_ff; mnl_in = mnl_ff; ec_in = ec_ff; eil_in = eil_ff;
      rsp_in = rsp_ff; load_rsp = 1'b0; job_ready = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            k_in = (AW+3)'(HDR_RID_OFF); fld_in = '0; bc_in = '0; ok_in = 1'b1;
            big_in = 1'b0; w_in = '0;
            rsp_in = '0;
            if (job_valid && !job_frame && !job_read)
               rsp_in.kind = job_lost ? KIND_LOST : KIND_TAKEN;
            // offset 5 vs len-1: a frame of len <= 6 fails the first check here
            if ({2'b0, job_len} <= (AW+3)'(HDR_RID_OFF + 1)) ok_in = 1'b0;
         end
         ST_RDREQ: begin
            rsp_in = '0;
            rsp_in.kind = KIND_READ;
            rsp_in.read_byte = ({1'b0, job_offset} >= 13'(job_len)) ? 8'd0 : rdata_ff;
         end
         ST_WALK: begin
            w_in  = wnext;
            bc_in = bc_ff + 2'd1;
            k_in  = k_ff + 1'b1;
            if (bc_ff == 2'd3) begin
               unique case (fld_ff)
                  2'd0: rid_in = wnext;
                  2'd1: mnl_in = wnext;
                  2'd2: ec_in  = wnext;
                  default: eil_in = wnext;
               endcase
               fld_in = fld_ff + 2'd1;
               // jump over the variable-length string that follows
               if (fld_ff == 2'd0 || fld_ff == 2'd1) begin
                  // a length past the address range leaves the rest of the walk outside
                  if (wnext[31:AW+1] != '0) big_in = 1'b1;
                  if (wnext[31:AW+1] != '0 ||
                      {1'b0, k_ff} + 1'b1 + {2'b0, wnext[AW:0]} >= {3'b0, job_len} - 1'b1)
                     ok_in = 1'b0;
                  k_in = k_ff + 1'b1 + (AW+3)'(wnext[AW:0]);
               end else if (fld_ff == 2'd2) begin
                  if ({1'b0, k_ff} + 1'b1 >= {3'b0, job_len} - 1'b1) ok_in = 1'b0;
               end
            end
         end
         ST_CALC: begin
            rsp_in.kind            = KIND_FRAME;
            rsp_in.frame_ok        = ok_ff && !dl[35];
            rsp_in.frame_base      = 12'(job_base);
            rsp_in.frame_len       = 13'(job_len);
            rsp_in.req_id_len      = sat({4'b0, rid_ff});
            rsp_in.method_name_len = sat({4'b0, mnl_ff});
            rsp_in.err_code        = ec_ff;
            rsp_in.err_info_len    = sat({4'b0, eil_ff});
            rsp_in.data_len        = dl[35] ? 13'd0 : sat(dl);
            rsp_in.read_byte       = '0;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp  = 1'b1;
               job_ready = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Hold walk state, the staged result and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      k_ff <= k_in; fld_ff <= fld_in; bc_ff <= bc_in; w_ff <= w_in; ok_ff <= ok_in;
      big_ff <= big_in; rid_ff <= rid_in; mnl_ff <= mnl_in; ec_ff <= ec_in;
      eil_ff <= eil_in;
      if (st_ff != ST_OUT) rsp_ff <= rsp_in;
      if (load_rsp) rsp_out_ff <= rsp_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp = rsp_out_ff;
   end
endmodule
`default_nettype wire

/* src/rpc_frame_deframer.sv */
// Frame deframer: stream bytes in, completed-frame header reports and read-back
// replies out. Top level; instantiates rfd_front and rfd_back, uses rfd_pkg.
//
// Each request gives exactly one response. A pushed byte passes the back-end states
// ST_IDLE and ST_OUT, a read-back ST_IDLE, ST_RDREQ and ST_OUT, and the next
// request is taken on the edge that loads the response. The byte that completes
// a frame walks the 16 header bytes through the single read port of the byte
// store, each in ST_RDWAIT then ST_WALK, then passes ST_CALC and ST_OUT; the
// string skips are jumps and read no bytes. While a response waits, the
// back end holds, the one-entry queue between front and back fills and
// req_ready drops.
`default_nettype none
module rpc_frame_deframer #(
   parameter int STORE_DEPTH = rfd_pkg::STORE_DEPTH_DEF,
   parameter int MAX_PENDING = rfd_pkg::MAX_PENDING_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rfd_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rfd_pkg::rsp_type       rsp_payload
);
   import rfd_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   logic [7:0] smark_ff, emark_ff;
   logic job_valid, job_ready, job_frame, job_read, job_lost, st_we;
   logic [AW-1:0] job_base, st_waddr;
   logic [AW:0] job_len;
   logic [11:0] job_offset;
   logic [7:0] st_wdata;

   // Marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         smark_ff <= 8'd2; emark_ff <= 8'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START: smark_ff <= csr_wdata;
            CSR_END:   emark_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   rfd_front #(.STORE_DEPTH(STORE_DEPTH), .MAX_PENDING(MAX_PENDING), .AW(AW)) u_front (
      .clock, .reset, .start_marker(smark_ff), .end_marker(emark_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_req(req_payload),
      .job_valid, .job_ready, .job_frame, .job_read, .job_lost, .job_base, .job_len,
      .job_offset, .st_we, .st_waddr, .st_wdata);

   rfd_back #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_back (
      .clock, .reset, .st_we, .st_waddr, .st_wdata,
      .job_valid, .job_ready, .job_frame, .job_read, .job_lost, .job_base, .job_len,
      .job_offset, .rsp_valid, .rsp_ready, .rsp(rsp_payload));
endmodule
`default_nettype wire

/* src/rfd_checker.sv */
// Port checker for the frame deframer, bound to the top level.
// Uses rfd_pkg.
`default_nettype none
module rfd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rfd_pkg::rsp_type rsp_payload
);
   import rfd_pkg::*;

   // Stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed under stall");

   // Read replies carry only the byte: the frame length must be zero
   a_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_READ |-> rsp_payload.frame_len == '0)
      else $error("read reply with frame fields");

   // Frame reports never claim more payload than the frame
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_FRAME |->
      rsp_payload.data_len <= rsp_payload.frame_len)
      else $error("payload longer than frame");
endmodule

bind rpc_frame_deframer rfd_checker u_rfd_checker (.*);
`default_nettype wire
